/* sv/gmsr_pkg.sv */
// Shared constants, key tables and frame builder for the gamepad/mouse serial reporter.
// No dependencies; used by the interfaces, the top level and the testbench.
package gmsr_pkg;

	localparam int FrameW = 32;
	localparam int BtnW   = 12;
	localparam int MotW   = 8;
	localparam int KeyW   = 16;
	localparam int KindW  = 2;
	localparam int RunW   = 6;
	localparam int LevelW = 2;
	localparam int BitsW  = 2;

	// Item kinds
	localparam logic [KindW-1:0] KIND_KEY   = 2'd0;
	localparam logic [KindW-1:0] KIND_LATCH = 2'd1;
	localparam logic [KindW-1:0] KIND_CLOCK = 2'd2;

	localparam logic [RunW-1:0]   RunSat     = 6'd32;
	localparam logic [RunW-1:0]   RunTrigger = 6'd31;
	localparam logic [BitsW-1:0]  BitsSat    = 2'd3;
	localparam logic [BitsW-1:0]  BitsShort  = 2'd2;
	localparam logic [LevelW-1:0] LevelMax   = 2'd2;

	typedef logic [BtnW-1:0] btn_mask_t;

	typedef struct packed {
		logic x_up;
		logic x_dn;
		logic y_up;
		logic y_dn;
	} mouse_dir_t;

	// Button table: key code to button bit
	function automatic btn_mask_t btn_mask(input logic [KeyW-1:0] code);
		btn_mask_t m;
		case (code)
			16'h0072: m = 12'h800;
			16'h006C: m = 12'h400;
			16'h0078: m = 12'h200;
			16'h0061: m = 12'h100;
			16'hFF53: m = 12'h080;
			16'hFF51: m = 12'h040;
			16'hFF54: m = 12'h020;
			16'hFF52: m = 12'h010;
			16'h0073: m = 12'h008;
			16'h0020: m = 12'h004;
			16'h0079: m = 12'h002;
			16'h0062: m = 12'h001;
			default:  m = '0;
		endcase
		return m;
	endfunction

	// Mouse table: key code to motion direction
	function automatic mouse_dir_t mouse_dir(input logic [KeyW-1:0] code);
		mouse_dir_t d;
		d = '0;
		case (code)
			16'hFFB2, 16'h006A: d.y_up = 1'b1;
			16'hFFB8, 16'h006B: d.y_dn = 1'b1;
			16'hFFB6, 16'h006C: d.x_up = 1'b1;
			16'hFFB4, 16'h0068: d.x_dn = 1'b1;
			default:            d = '0;
		endcase
		return d;
	endfunction

	// Low seven bits of |v|; -128 gives zero
	function automatic logic [MotW-2:0] mag7(input logic [MotW-1:0] v);
		logic [MotW-1:0] neg;
		neg = ~v + MotW'(1);
		return v[MotW-1] ? neg[MotW-2:0] : v[MotW-2:0];
	endfunction

	// Active-low report frame
	function automatic logic [FrameW-1:0] build_frame(
		input btn_mask_t         buttons,
		input logic              mouse_mode,
		input logic [LevelW-1:0] level,
		input logic [MotW-1:0]   mx,
		input logic [MotW-1:0]   my
	);
		logic [FrameW-1:0] f;
		logic [MotW-2:0]   mag_x;
		logic [MotW-2:0]   mag_y;
		f     = ~{{(FrameW-BtnW){1'b0}}, buttons};
		mag_x = mag7(mx);
		mag_y = mag7(my);
		if (mouse_mode) begin
			f[11:10] = ~level;
			f[15]    = 1'b0;
			f[16]    = ~my[MotW-1];
			f[24]    = ~mx[MotW-1];
			for (int i = 0; i < MotW-1; i++) begin
				f[23-i] = ~mag_y[i];
				f[31-i] = ~mag_x[i];
			end
		end
		return f;
	endfunction

endpackage

/* sv/gmsr_ifs.sv */
// Handshake interfaces for the reporter: event input, serial bit output, mode write.
// Depends on gmsr_pkg.
interface gmsr_evt_if import gmsr_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [KindW-1:0] kind;
	logic [KeyW-1:0]  key_code;
	logic             key_down;
	modport source(output valid, kind, key_code, key_down, input ready);
	modport sink(input valid, kind, key_code, key_down, output ready);
endinterface

interface gmsr_rsp_if;
	logic valid;
	logic ready;
	logic data_bit;
	modport source(output valid, data_bit, input ready);
	modport sink(input valid, data_bit, output ready);
endinterface

interface gmsr_cfg_if;
	logic valid;
	logic ready;
	logic mouse_mode;
	modport source(output valid, mouse_mode, input ready);
	modport sink(input valid, mouse_mode, output ready);
endinterface

/* sv/gamepad_mouse_serial_reporter_unit.sv */
// Gamepad-with-mouse serial reporter, top level.
// Depends on gmsr_pkg and the interfaces in gmsr_ifs.sv.
//
// Takes one event transaction per clock cycle unless the input is held: a key event
// (updates held buttons or mouse motion), a latch edge, or a clock edge of the
// controller line. Latch and clock edges each produce one response transaction
// carrying the serial data bit; key events and the unused kind produce none. An
// event is captured in an input register and all of its work (table compare, frame
// build, shift) is done from that register, where the state registers and the
// output register update; the result is presented from the output register.
// Throughput is one event per cycle, set by that single state-update stage; the
// output register lets a new event be taken while a finished bit still waits, and
// only a stalled response with a second bit-producing event behind it holds the
// input. The mode register may be written in any cycle; it should change only
// while no event is in flight.
module gamepad_mouse_serial_reporter_unit import gmsr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	gmsr_cfg_if.sink  cfg,
	gmsr_evt_if.sink  evt,
	gmsr_rsp_if.source rsp
);

	// Input register
	logic             valid_s1;
	logic [KindW-1:0] kind_s1;
	logic [KeyW-1:0]  code_s1;
	logic             down_s1;

	// Device state
	logic              mouse_mode_q;
	btn_mask_t         buttons_q;
	logic [FrameW-1:0] shifter_q;
	logic [MotW-1:0]   mot_x_q;
	logic [MotW-1:0]   mot_y_q;
	logic [BitsW-1:0]  bits_q;
	logic [RunW-1:0]   run_q;
	logic [LevelW-1:0] level_q;

	// Output register
	logic out_valid_q;
	logic out_bit_q;

	logic              has_result;
	logic              advance;
	btn_mask_t         mask;
	mouse_dir_t        dir;
	logic [MotW-1:0]   step;
	logic [FrameW-1:0] frame;
	logic [RunW-1:0]   run_inc;
	logic              short_gap;
	logic              level_step;
	logic [LevelW-1:0] level_next;
	logic              result_bit;

	// Move the held item on unless it makes a bit and the output stage is full and stalled
	assign has_result = (kind_s1 == KIND_LATCH) || (kind_s1 == KIND_CLOCK);
	assign advance    = valid_s1 && (!has_result || !out_valid_q || rsp.ready);
	assign evt.ready  = !valid_s1 || advance;

	assign cfg.ready    = 1'b1;
	assign rsp.valid    = out_valid_q;
	assign rsp.data_bit = out_bit_q;

	// Table lookups and frame build; a latch that completes a run reports the new level
	assign mask       = btn_mask(code_s1);
	assign dir        = mouse_dir(code_s1);
	assign step       = MotW'(level_q) + MotW'(1);
	assign run_inc    = (run_q == RunSat) ? run_q : run_q + RunW'(1);
	assign short_gap  = (bits_q == BitsShort);
	assign level_step = short_gap && (run_inc == RunTrigger);
	assign level_next = !level_step ? level_q :
			    (level_q == LevelMax) ? '0 : level_q + LevelW'(1);
	assign frame      = build_frame(buttons_q, mouse_mode_q, level_next, mot_x_q, mot_y_q);
	assign result_bit = (kind_s1 == KIND_LATCH) ? frame[0] : shifter_q[0];

	// Capture the incoming event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			kind_s1 <= evt.kind;
			code_s1 <= evt.key_code;
			down_s1 <= evt.key_down;
		end
	end

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mouse_mode_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			mouse_mode_q <= cfg.mouse_mode;
		end
	end

	// State update, one event per cycle while the held item advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buttons_q <= '0;
			shifter_q <= '0;
			mot_x_q   <= '0;
			mot_y_q   <= '0;
			bits_q    <= '0;
			run_q     <= '0;
			level_q   <= '0;
		end else if (advance) begin
			case (kind_s1)
				KIND_KEY: begin
					// Set or drop the matched button bit
					buttons_q <= down_s1 ? (buttons_q | mask) : (buttons_q & ~mask);
					// Press and release both move the pointer
					if (dir.x_up) begin
						mot_x_q <= mot_x_q + step;
					end else if (dir.x_dn) begin
						mot_x_q <= mot_x_q - step;
					end
					if (dir.y_up) begin
						mot_y_q <= mot_y_q + step;
					end else if (dir.y_dn) begin
						mot_y_q <= mot_y_q - step;
					end
				end
				KIND_LATCH: begin
					// Count runs of latches one clock apart; step sensitivity at 31
					if (short_gap) begin
						run_q   <= run_inc;
						level_q <= level_next;
					end else begin
						run_q <= '0;
					end
					// Bit 0 goes out now; keep the rest
					shifter_q <= frame >> 1;
					bits_q    <= BitsW'(1);
					if (mouse_mode_q) begin
						mot_x_q <= '0;
						mot_y_q <= '0;
					end
				end
				KIND_CLOCK: begin
					shifter_q <= shifter_q >> 1;
					if (bits_q != BitsSat) begin
						bits_q <= bits_q + BitsW'(1);
					end
				end
				default: begin
					// Unused kind: no state change
				end
			endcase
		end
	end

	// Output register: hold until the response transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_bit_q <= result_bit;
		end
	end

endmodule

/* sv/gmsr_checker.sv */
// Port-level checker for the reporter, with its bind to the top level.
// Depends on gamepad_mouse_serial_reporter_unit and the interfaces in gmsr_ifs.sv.
module gmsr_checker (
	input logic clk,
	input logic arst_n,
	input logic evt_valid,
	input logic evt_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_data_bit,
	input logic cfg_valid,
	input logic cfg_ready
);

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_bit))
		else $error("response dropped or changed while stalled");

	// A fresh response is traced back to an accepted event
	a_rsp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(evt_valid && evt_ready, 2))
		else $error("response without an event two cycles before");

	// An empty output stage never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> evt_ready)
		else $error("input stalled with empty output");

	// Mode writes are always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("mode write refused");

endmodule

bind gamepad_mouse_serial_reporter_unit gmsr_checker u_gmsr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.evt_valid    (evt.valid),
	.evt_ready    (evt.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_data_bit (rsp.data_bit),
	.cfg_valid    (cfg.valid),
	.cfg_ready    (cfg.ready)
);

/* tb/gamepad_mouse_serial_reporter_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for gamepad_mouse_serial_reporter_unit: key, latch and clock
// events in, serial data bits out. Depends on gmsr_pkg and the interfaces in gmsr_ifs.sv.
module gamepad_mouse_serial_reporter_unit_tb;
	import gmsr_pkg::*;

	// Kind code that the block must ignore
	localparam logic [KindW-1:0] KIND_SPARE = 2'd3;

	// Twelve button keys followed by eight mouse keys
	localparam int KEY_COUNT      = 20;
	// Items per phase that reach the block's logic
	localparam int PHASE_ITEMS    = 110;
	// Cycles a key event may still sit in the pipeline after the last bit came out
	localparam int PIPE_SETTLE    = 6;
	// Cycles without any transaction before giving up
	localparam int WATCHDOG_LIMIT = 2000;

	// Mouse keys come in groups of four: y up, y down, x up, x down
	typedef enum int {MOVE_Y_UP, MOVE_Y_DOWN, MOVE_X_UP, MOVE_X_DOWN} move_dir_t;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [KeyW-1:0]  code;
		logic             down;
	} line_event_t;

	logic clk = 1'b0;
	logic arst_n;

	gmsr_cfg_if cfg_ch();
	gmsr_evt_if evt_ch();
	gmsr_rsp_if rsp_ch();

	gamepad_mouse_serial_reporter_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.evt    (evt_ch),
		.rsp    (rsp_ch)
	);

	always #1 clk = ~clk;

	// Events waiting to be offered, and data bits predicted but not yet seen
	line_event_t pending_events[$];
	logic        expected_bits[$];

	// Shadow copy of the reporter's state and its mode register
	logic               cur_mouse_mode;
	logic [BtnW-1:0]    held_buttons;
	logic [FrameW-1:0]  report_frame;
	logic [MotW-1:0]    delta_x;
	logic [MotW-1:0]    delta_y;
	logic [BitsW-1:0]   shifts_since_latch;
	logic [RunW-1:0]    quick_latch_run;
	logic [LevelW-1:0]  sens_level;

	int  sender_idle_pct    = 0;
	int  receiver_stall_pct = 0;
	bit  evt_taken          = 1'b0;
	int  mismatch_count     = 0;
	int  idle_cycles        = 0;
	int  live_items         = 0;
	int  bits_checked       = 0;
	int  latch_count        = 0;
	int  clock_count        = 0;
	int  key_count          = 0;
	int  level_steps        = 0;
	int  phase_count        = 0;

	// Key table in scan order: button keys map to bit 11 down to bit 0,
	// mouse keys follow in move_dir_t order, two sets of four.
	function automatic logic [KeyW-1:0] table_key(input int idx);
		case (idx)
			0:  return 16'h0072;
			1:  return 16'h006C;
			2:  return 16'h0078;
			3:  return 16'h0061;
			4:  return 16'hFF53;
			5:  return 16'hFF51;
			6:  return 16'hFF54;
			7:  return 16'hFF52;
			8:  return 16'h0073;
			9:  return 16'h0020;
			10: return 16'h0079;
			11: return 16'h0062;
			12: return 16'hFFB2;
			13: return 16'hFFB8;
			14: return 16'hFFB6;
			15: return 16'hFFB4;
			16: return 16'h006A;
			17: return 16'h006B;
			18: return 16'h006C;
			19: return 16'h0068;
			default: return 16'h0000;
		endcase
	endfunction

	// Drive the next frame bit and refill with zero
	function automatic logic shift_frame();
		logic b;
		b = report_frame[0];
		report_frame = report_frame >> 1;
		if (shifts_since_latch < BitsSat)
			shifts_since_latch = shifts_since_latch + 1'b1;
		return b;
	endfunction

	// Apply one accepted event to the shadow state; queue the bit it produces
	function automatic void advance_model(input line_event_t ev);
		logic [MotW-1:0] step;
		logic [MotW-1:0] mag_x;
		logic [MotW-1:0] mag_y;
		step = MotW'(sens_level) + 1'b1;
		case (ev.kind)
			KIND_KEY: begin
				key_count++;
				// A code may hit both tables (the 'l' key), so scan both in full
				for (int i = 0; i < BtnW; i++)
					if (ev.code == table_key(i))
						held_buttons[BtnW-1-i] = ev.down;
				// Motion moves on press and on release alike
				for (int i = BtnW; i < KEY_COUNT; i++) begin
					if (ev.code == table_key(i)) begin
						case ((i - BtnW) % 4)
							MOVE_Y_UP:   delta_y = delta_y + step;
							MOVE_Y_DOWN: delta_y = delta_y - step;
							MOVE_X_UP:   delta_x = delta_x + step;
							MOVE_X_DOWN: delta_x = delta_x - step;
							default: ;
						endcase
					end
				end
			end
			KIND_LATCH: begin
				latch_count++;
				// Exactly two shifts since the last latch means one clock in between
				if (shifts_since_latch == BitsShort) begin
					if (quick_latch_run < RunSat)
						quick_latch_run = quick_latch_run + 1'b1;
					if (quick_latch_run == RunTrigger) begin
						sens_level = (sens_level == LevelMax) ? '0 : sens_level + 1'b1;
						level_steps++;
					end
				end else begin
					quick_latch_run = '0;
				end
				report_frame = {{(FrameW-BtnW){1'b1}}, ~held_buttons};
				if (cur_mouse_mode) begin
					// Sign and 7-bit magnitude, active low; -128 reads as zero magnitude
					mag_x = delta_x[MotW-1] ? (8'd0 - delta_x) : delta_x;
					mag_y = delta_y[MotW-1] ? (8'd0 - delta_y) : delta_y;
					report_frame[11:10] = ~sens_level;
					report_frame[15]    = 1'b0;
					report_frame[16]    = ~delta_y[MotW-1];
					report_frame[24]    = ~delta_x[MotW-1];
					for (int k = 0; k < MotW-1; k++) begin
						report_frame[23-k] = ~mag_y[k];
						report_frame[31-k] = ~mag_x[k];
					end
					delta_x = '0;
					delta_y = '0;
				end
				shifts_since_latch = '0;
				expected_bits.push_back(shift_frame());
			end
			KIND_CLOCK: begin
				clock_count++;
				expected_bits.push_back(shift_frame());
			end
			default: ;
		endcase
	endfunction

	// Queue one event; count it toward the phase only if the block acts on it
	function automatic void push_event(input logic [KindW-1:0] kind,
					   input logic [KeyW-1:0] code, input logic down);
		line_event_t ev;
		bit          acts;
		ev.kind = kind;
		ev.code = code;
		ev.down = down;
		pending_events.push_back(ev);
		acts = (kind == KIND_LATCH) || (kind == KIND_CLOCK);
		if (kind == KIND_KEY)
			for (int i = 0; i < KEY_COUNT; i++)
				if (code == table_key(i))
					acts = 1'b1;
		if (acts)
			live_items++;
	endfunction

	// Hold until every queued event went in and every predicted bit came out
	task automatic wait_drained();
		while (pending_events.size() != 0 || expected_bits.size() != 0)
			@(posedge clk);
	endtask

	// One phase: write the mode while idle, set the idling mix, queue random traffic
	task automatic run_phase(input logic mode, input int idle_pct, input int stall_pct);
		int sel;
		int n;
		int start;
		int idx;
		wait_drained();
		// Key events leave no bit behind, so let the pipeline empty out
		repeat (PIPE_SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.mouse_mode <= mode;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		phase_count++;
		start = live_items;
		while (live_items - start < PHASE_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 25) begin
				// Burst of key presses and releases, mostly table keys
				n = $urandom_range(1, 8);
				repeat (n) begin
					if ($urandom_range(0, 99) < 85)
						push_event(KIND_KEY, table_key($urandom_range(0, KEY_COUNT-1)),
							   1'($urandom_range(0, 1)));
					else
						push_event(KIND_KEY, 16'($urandom_range(0, 65535)),
							   1'($urandom_range(0, 1)));
				end
			end else if (sel < 50) begin
				// Latch and read out part of the frame, or run past its end
				push_event(KIND_LATCH, 16'($urandom_range(0, 65535)),
					   1'($urandom_range(0, 1)));
				n = $urandom_range(0, 35);
				repeat (n)
					push_event(KIND_CLOCK, 16'($urandom_range(0, 65535)),
						   1'($urandom_range(0, 1)));
			end else if (sel < 67) begin
				// Chain of latches one clock apart; a rare extra clock breaks the run
				push_event(KIND_LATCH, '0, 1'b0);
				n = $urandom_range(28, 40);
				repeat (n) begin
					push_event(KIND_CLOCK, '0, 1'b0);
					if ($urandom_range(0, 39) == 0)
						push_event(KIND_CLOCK, '1, 1'b1);
					if ($urandom_range(0, 4) == 0)
						push_event(KIND_KEY, table_key($urandom_range(0, KEY_COUNT-1)),
							   1'($urandom_range(0, 1)));
					push_event(KIND_LATCH, '0, 1'b0);
				end
			end else if (sel < 85) begin
				// Long burst on one mouse key to drive the deltas round
				idx = $urandom_range(BtnW, KEY_COUNT-1);
				n   = $urandom_range(10, 50);
				repeat (n)
					push_event(KIND_KEY, table_key(idx), 1'($urandom_range(0, 1)));
			end else begin
				// Noise: any kind, any code
				n = $urandom_range(1, 6);
				repeat (n)
					push_event(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
						   1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Driver: offer the head of the queue at the falling edge, hold it until taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (evt_ch.valid && !evt_taken) begin
				// hold the current transaction
			end else if (pending_events.size() != 0 &&
				     $urandom_range(0, 99) >= sender_idle_pct) begin
				evt_ch.valid    <= 1'b1;
				evt_ch.kind     <= pending_events[0].kind;
				evt_ch.key_code <= pending_events[0].code;
				evt_ch.key_down <= pending_events[0].down;
			end else begin
				evt_ch.valid <= 1'b0;
			end
			evt_taken = 1'b0;
			rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	// Predict at acceptance: event transactions advance the shadow state,
	// mode writes update the shadow register
	always @(posedge clk) begin
		if (arst_n) begin
			if (evt_ch.valid && evt_ch.ready) begin
				evt_taken = 1'b1;
				advance_model(pending_events.pop_front());
			end
			if (cfg_ch.valid && cfg_ch.ready)
				cur_mouse_mode = cfg_ch.mouse_mode;
		end
	end

	// Monitor: compare each response transaction with the oldest predicted bit
	always @(posedge clk) begin
		logic want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_bits.size() == 0) begin
				$error("data_bit: no bit expected, actual %0b", rsp_ch.data_bit);
				mismatch_count++;
			end else begin
				want = expected_bits.pop_front();
				bits_checked++;
				if (rsp_ch.data_bit !== want) begin
					$error("data_bit: expected %0b, actual %0b", want, rsp_ch.data_bit);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: end the run if no transaction of any kind moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((evt_ch.valid && evt_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			    (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: %0d events and %0d bits still outstanding",
					 pending_events.size(), expected_bits.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		// Known values on every input before and during reset
		arst_n            = 1'b0;
		evt_ch.valid      = 1'b0;
		evt_ch.kind       = KIND_KEY;
		evt_ch.key_code   = '0;
		evt_ch.key_down   = 1'b0;
		rsp_ch.ready      = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.mouse_mode = 1'b1;
		// Shadow state at reset: mouse mode on, everything else clear
		cur_mouse_mode     = 1'b1;
		held_buttons       = '0;
		report_frame       = '0;
		delta_x            = '0;
		delta_y            = '0;
		shifts_since_latch = '0;
		quick_latch_run    = '0;
		sens_level         = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opening, mouse mode from reset, no idling.
		// Unused kind and unmapped codes at both extremes change nothing.
		push_event(KIND_SPARE, 16'hFFFF, 1'b1);
		push_event(KIND_KEY, 16'h0000, 1'b0);
		push_event(KIND_KEY, 16'hFFFF, 1'b1);
		// Hold every button, 'l' included, which also moves x
		for (int i = 0; i < BtnW; i++)
			push_event(KIND_KEY, table_key(i), 1'b1);
		// Motion on press and on release
		push_event(KIND_KEY, 16'hFFB2, 1'b1);
		push_event(KIND_KEY, 16'hFFB8, 1'b0);
		push_event(KIND_KEY, 16'hFFB4, 1'b1);
		push_event(KIND_LATCH, 16'h0000, 1'b0);
		push_event(KIND_CLOCK, 16'hFFFF, 1'b1);
		push_event(KIND_CLOCK, 16'h0000, 1'b0);
		push_event(KIND_KEY, 16'h006C, 1'b0);
		push_event(KIND_LATCH, 16'h0000, 1'b0);
		push_event(KIND_CLOCK, 16'h0000, 1'b0);
		push_event(KIND_LATCH, 16'h0000, 1'b0);

		// Random phases over both modes and every idling mix
		run_phase(1'b0, 0, 0);
		run_phase(1'b1, 46, 0);
		run_phase(1'b0, 0, 46);
		run_phase(1'b1, 23, 23);
		run_phase(1'b1, 0, 0);
		run_phase(1'b0, 46, 0);
		run_phase(1'b1, 0, 46);
		run_phase(1'b0, 23, 23);

		wait_drained();
		repeat (PIPE_SETTLE) @(posedge clk);
		$display("Covered %0d phases: %0d key events, %0d latches, %0d clocks, %0d bits checked",
			 phase_count, key_count, latch_count, clock_count, bits_checked);
		$display("Sensitivity stepped %0d times through fast latch runs", level_steps);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* gamepad_mouse_serial_reporter_unit.f */
sv/gmsr_pkg.sv
sv/gmsr_ifs.sv
sv/gamepad_mouse_serial_reporter_unit.sv
sv/gmsr_checker.sv
tb/gamepad_mouse_serial_reporter_unit_tb.sv
